// File: design/kst_pkg.sv
// Shared types and codes for the keyed signature table.
`default_nettype none

package kst_pkg;

   localparam int OP_W   = 3;
   localparam int ID_W   = 32;
   localparam int SIG_W  = 64;
   localparam int STAT_W = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_UPSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
   localparam logic [OP_W-1:0] OP_LOOKUP = 3'd4;

   localparam logic [STAT_W-1:0] STS_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STS_DUPLICATE = 2'd1;
   localparam logic [STAT_W-1:0] STS_NOT_FOUND = 2'd2;
   localparam logic [STAT_W-1:0] STS_FULL      = 2'd3;

   // Update issued to the entry store at the end of an operation.
   typedef struct packed {
      logic write_entry;
      logic set_valid;
      logic clear_valid;
      logic clear_all;
   } kst_cmd_type;

endpackage

`default_nettype wire

// File: design/kst_if.sv
// Request and response channel interfaces of the keyed signature table.
`default_nettype none

interface kst_req_if;
   import kst_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [ID_W-1:0]   entity_id;
   logic [SIG_W-1:0]  signature;

   modport source (output valid, output operation, output entity_id, output signature,
                   input ready);
   modport sink   (input valid, input operation, input entity_id, input signature,
                   output ready);
endinterface

interface kst_rsp_if;
   import kst_pkg::*;

   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic              found;
   logic [SIG_W-1:0]  signature_out;

   modport source (output valid, output status, output found, output signature_out,
                   input ready);
   modport sink   (input valid, input status, input found, input signature_out,
                   output ready);
endinterface

`default_nettype wire

// File: design/kst_store.sv
// Entry store: id and signature memory with its valid bits.
`default_nettype none

module kst_store #(
   parameter int CAPACITY       = 64,
   parameter int SIGNATURE_BITS = 64,
   parameter int AW             = 6
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      rd_en,
   input  wire logic [AW-1:0]             rd_addr,
   output logic                           rd_valid,
   output logic [kst_pkg::ID_W-1:0]       rd_id,
   output logic [SIGNATURE_BITS-1:0]      rd_sig,
   input  wire kst_pkg::kst_cmd_type      cmd,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [kst_pkg::ID_W-1:0]  wr_id,
   input  wire logic [SIGNATURE_BITS-1:0] wr_sig
);
   import kst_pkg::*;

   localparam int ENTRY_W = ID_W + SIGNATURE_BITS;

   logic [ENTRY_W-1:0]  mem [CAPACITY];
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic                rd_valid_ff;
   logic [CAPACITY-1:0] valid_ff;
   logic [CAPACITY-1:0] valid_in;

   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         mem[wr_addr] <= {wr_id, wr_sig};
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      priority if (cmd.clear_all) begin
         valid_in = '0;
      end else if (cmd.set_valid) begin
         valid_in[wr_addr] = 1'b1;
      end else if (cmd.clear_valid) begin
         valid_in[wr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_id    = rd_data_ff[ENTRY_W-1:SIGNATURE_BITS];
   assign rd_sig   = rd_data_ff[SIGNATURE_BITS-1:0];

endmodule

`default_nettype wire

// File: design/keyed_signature_table_core.sv
// Top level of the keyed signature table: scan sequencer and response register.
//
//   channel | direction | handshake    | payload
//   req     | in        | valid/ready  | operation, entity_id, signature
//   rsp     | out       | valid/ready  | status, found, signature_out
//
// Every operation scans all CAPACITY entries through the single read port of
// the entry memory, one entry per cycle, and then registers its result.
// Reset is synchronous and empties the table at once through the valid bits.
// A new request is taken while a result still waits; the next result is held
// back in its final step until the response register is free.
`default_nettype none

module keyed_signature_table_core #(
   parameter int CAPACITY       = 64,
   parameter int SIGNATURE_BITS = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   kst_req_if.sink   req_chan,
   kst_rsp_if.source rsp_chan
);
   import kst_pkg::*;

   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = AW + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [OP_W-1:0]           op_ff;
   logic [ID_W-1:0]           key_ff;
   logic [SIGNATURE_BITS-1:0] sig_ff;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      pend_ff, pend_in;
   logic [AW-1:0]             pend_idx_ff;
   logic                      hit_ff, hit_in;
   logic [AW-1:0]             hit_idx_ff, hit_idx_in;
   logic [SIGNATURE_BITS-1:0] hit_sig_ff, hit_sig_in;
   logic                      free_ff, free_in;
   logic [AW-1:0]             free_idx_ff, free_idx_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]         rsp_status_ff;
   logic                      rsp_found_ff;
   logic [SIG_W-1:0]          rsp_sig_ff;

   logic                      req_fire;
   logic                      issue;
   logic                      done_fire;
   logic                      rd_valid;
   logic [ID_W-1:0]           rd_id;
   logic [SIGNATURE_BITS-1:0] rd_sig;
   kst_cmd_type               cmd;
   logic [AW-1:0]             wr_addr;
   logic [STAT_W-1:0]         status;
   logic [SIG_W-1:0]          sig_out;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == S_IDLE);
   assign issue          = (state_ff == S_SCAN) && (cnt_ff < CNT_W'(CAPACITY));
   assign done_fire      = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   kst_store #(
      .CAPACITY       (CAPACITY),
      .SIGNATURE_BITS (SIGNATURE_BITS),
      .AW             (AW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (issue),
      .rd_addr  (cnt_ff[AW-1:0]),
      .rd_valid (rd_valid),
      .rd_id    (rd_id),
      .rd_sig   (rd_sig),
      .cmd      (cmd),
      .wr_addr  (wr_addr),
      .wr_id    (key_ff),
      .wr_sig   (sig_ff)
   );

   // Scan sequencing: one read issued per cycle, its data checked in the cycle after.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      pend_in     = 1'b0;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_sig_in  = hit_sig_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_SCAN;
               cnt_in   = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
            end
         end
         S_SCAN: begin
            pend_in = issue;
            if (issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               if (rd_valid && (rd_id == key_ff) && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = pend_idx_ff;
                  hit_sig_in = rd_sig;
               end
               if (!rd_valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = pend_idx_ff;
               end
            end
            if (!issue && !pend_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (done_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Final step: table update and result for the scanned operation.
   always_comb begin
      cmd     = '0;
      wr_addr = hit_idx_ff;
      status  = STS_OK;
      sig_out = '0;
      unique case (op_ff)
         OP_INSERT: begin
            if (hit_ff) begin
               status = STS_DUPLICATE;
            end else if (free_ff) begin
               cmd.write_entry = done_fire;
               cmd.set_valid   = done_fire;
               wr_addr         = free_idx_ff;
            end else begin
               status = STS_FULL;
            end
         end
         OP_UPSERT: begin
            if (hit_ff) begin
               cmd.write_entry = done_fire;
            end else if (free_ff) begin
               cmd.write_entry = done_fire;
               cmd.set_valid   = done_fire;
               wr_addr         = free_idx_ff;
            end else begin
               status = STS_FULL;
            end
         end
         OP_REMOVE: begin
            if (hit_ff) begin
               cmd.clear_valid = done_fire;
            end else begin
               status = STS_NOT_FOUND;
            end
         end
         OP_CLEAR: begin
            cmd.clear_all = done_fire;
         end
         OP_LOOKUP: begin
            if (hit_ff) begin
               sig_out = SIG_W'(hit_sig_ff);
            end else begin
               status = STS_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (done_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      pend_idx_ff <= cnt_ff[AW-1:0];
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_sig_ff  <= hit_sig_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      if (req_fire) begin
         op_ff  <= req_chan.operation;
         key_ff <= req_chan.entity_id;
         sig_ff <= req_chan.signature[SIGNATURE_BITS-1:0];
      end
      if (done_fire) begin
         rsp_status_ff <= status;
         rsp_found_ff  <= hit_ff;
         rsp_sig_ff    <= sig_out;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.found         = rsp_found_ff;
   assign rsp_chan.signature_out = rsp_sig_ff;

endmodule

`default_nettype wire

// File: design/kst_checker.sv
// Port-level assertions for the keyed signature table, bound to the top level.
`default_nettype none

module kst_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [kst_pkg::STAT_W-1:0]  rsp_status,
   input wire logic                        rsp_found,
   input wire logic [kst_pkg::SIG_W-1:0]   rsp_signature_out
);
   import kst_pkg::*;

   // A stalled transfer keeps its result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_found) && $stable(rsp_signature_out))
      else $error("response changed while stalled");

   // Only a successful lookup returns signature bits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_signature_out != '0) |-> (rsp_status == STS_OK) && rsp_found)
      else $error("signature returned without a hit");

   // A duplicate report needs a hit; not-found and full need a miss.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STS_DUPLICATE) |-> rsp_found)
      else $error("duplicate reported without a hit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == STS_NOT_FOUND) || (rsp_status == STS_FULL)) |-> !rsp_found)
      else $error("miss status reported with a hit");

endmodule

bind keyed_signature_table_core kst_checker u_kst_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_found         (rsp_chan.found),
   .rsp_signature_out (rsp_chan.signature_out)
);

`default_nettype wire
